[hdl/steering_calibrate_and_position_core_macros.svh]
// Assertion helpers shared by the RTL that checks itself.
// Both forms sample on clk and stay quiet while rst_n is low.
`ifndef STEERING_CALIBRATE_AND_POSITION_CORE_MACROS_SVH
`define STEERING_CALIBRATE_AND_POSITION_CORE_MACROS_SVH

// Same-cycle implication.
`define SCP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scp check failed");

// Next-cycle implication.
`define SCP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scp check failed");

`endif

[hdl/scp_pkg.sv]
`default_nettype none

package scp_pkg;

    // Configuration register indexes
    typedef logic [0:0] cfg_index_t;
    localparam cfg_index_t CFG_TURN_DRIVE  = 1'b0;
    localparam cfg_index_t CFG_JITTER_BAND = 1'b1;

    localparam int CFG_DATA_BITS = 8;

    localparam logic [6:0] TURN_DRIVE_RST  = 7'd40;
    localparam logic [7:0] JITTER_BAND_RST = 8'd5;

    // Fixed behavior constants
    localparam logic [7:0] PWM_MAX     = 8'd100;
    localparam logic [7:0] SWEEP_BOOST = 8'd5;
    localparam int         MIN_SPAN    = 10;

    // Sweep / positioning phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_RIGHT  = 5'b00010,
        PH_LEFT   = 5'b00100,
        PH_CENTER = 5'b01000,
        PH_READY  = 5'b10000
    } phase_t;

endpackage

`default_nettype wire

[hdl/scp_in_if.sv]
`default_nettype none

interface scp_in_if #(
    parameter int COUNT_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COUNT_BITS-1:0] encoder_count;
    logic                         write_speed;
    logic signed [7:0]            speed_value;
    logic                         write_angle;
    logic signed [8:0]            angle_value;
    logic                         write_halt;
    logic                         halt_value;
    logic                         start_calibration;

    modport source (
        output valid, encoder_count, write_speed, speed_value, write_angle,
               angle_value, write_halt, halt_value, start_calibration,
        input  ready
    );

    modport sink (
        input  valid, encoder_count, write_speed, speed_value, write_angle,
               angle_value, write_halt, halt_value, start_calibration,
        output ready
    );
endinterface

`default_nettype wire

[hdl/scp_out_if.sv]
`default_nettype none

interface scp_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] drive_pwm;
    logic signed [7:0] steer_pwm;
    logic              zero_encoder;
    logic              is_calibrated;
    logic              is_centered;
    logic              calibrating;
    logic              speed_rejected;
    logic              angle_rejected;

    modport source (
        output valid, drive_pwm, steer_pwm, zero_encoder, is_calibrated,
               is_centered, calibrating, speed_rejected, angle_rejected,
        input  ready
    );

    modport sink (
        input  valid, drive_pwm, steer_pwm, zero_encoder, is_calibrated,
               is_centered, calibrating, speed_rejected, angle_rejected,
        output ready
    );
endinterface

`default_nettype wire

[hdl/steering_calibrate_and_position_core.sv]
`default_nettype none
// Channel   Dir  Beat contents
// --------  ---  ----------------------------------------------------------
// in_ch     in   encoder count, speed/angle/halt writes, calibration start
// out_ch    out  drive and steer commands, zero pulse, status and rejects
// cfg_*     in   write-only registers: turn_drive (0), jitter_band (1)
//
// One beat in, one beat out. A beat is taken on the cycle it arrives and its
// result sits in the output register on the next cycle; the input stays ready
// whenever the output register is empty or is being drained, so one beat per
// cycle flows through. The only path is combinational add/compare between
// the channel and the output register. rst_n (async, active low) returns the
// block to uncalibrated idle with registers at 40 and 5. An output stall holds
// the result and, once the register is full, backpressures the input.

module steering_calibrate_and_position_core #(
    parameter int COUNT_BITS  = 16,
    parameter int SPEED_LIMIT = 100,
    parameter int ANGLE_LIMIT = 90
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_write_enable,
    input  scp_pkg::cfg_index_t                  cfg_index,
    input  wire [scp_pkg::CFG_DATA_BITS-1:0]     cfg_data,
    scp_in_if.sink                               in_ch,
    scp_out_if.source                            out_ch
);
    import scp_pkg::*;

    // Counts are widened by one bit so differences and offsets never wrap.
    localparam int CW = COUNT_BITS;
    localparam int DW = COUNT_BITS + 1;

    localparam logic signed [9:0] SPD_HI = 10'(SPEED_LIMIT);
    localparam logic signed [9:0] SPD_LO = -SPD_HI;
    localparam logic signed [9:0] ANG_HI = 10'(ANGLE_LIMIT);
    localparam logic signed [9:0] ANG_LO = -ANG_HI;
    localparam logic signed [DW-1:0] SPAN = DW'(MIN_SPAN);

    // True when |a - b| <= tol.
    function automatic logic near(input logic signed [DW-1:0] a,
                                  input logic signed [DW-1:0] b,
                                  input logic [7:0] tol);
        logic signed [DW:0] d;
        logic [DW:0]        m;
        d = {a[DW-1], a} - {b[DW-1], b};
        m = d[DW] ? (~d + 1'b1) : d;
        return m <= {{(DW+1-8){1'b0}}, tol};
    endfunction

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [6:0] turn_reg;
    logic [7:0] jitter_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_reg   <= TURN_DRIVE_RST;
            jitter_reg <= JITTER_BAND_RST;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                CFG_TURN_DRIVE:  turn_reg   <= cfg_data[6:0];
                CFG_JITTER_BAND: jitter_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    phase_t                phase_reg,        phase_next;
    logic signed [CW-1:0]  prev_count_reg,   prev_count_next;
    logic                  prev_valid_reg,   prev_valid_next;
    logic signed [CW-1:0]  right_end_reg,    right_end_next;
    logic signed [CW-1:0]  mid_reg,          mid_next;       // midpoint of the ends
    logic signed [7:0]     speed_reg,        speed_next;
    logic signed [8:0]     angle_reg,        angle_next;
    logic                  halted_reg,       halted_next;

    // Output register
    logic                  out_valid_reg;
    logic signed [7:0]     drive_reg,   drive_next;
    logic signed [7:0]     steer_reg,   steer_next;
    logic                  zero_reg,    zero_next;
    logic                  iscal_reg,   iscal_next;
    logic                  center_reg,  center_next;
    logic                  calib_reg,   calib_next;
    logic                  srej_reg,    srej_next;
    logic                  arej_reg,    arej_next;

    logic in_fire;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // ---------------------------------------------------------------
    // Per-beat datapath
    // ---------------------------------------------------------------
    logic signed [DW-1:0] cnt_x, prev_x, right_x, mid_x, ang_x, lim_x;
    logic signed [DW-1:0] mid_sum, mid_adj;
    logic signed [9:0]    spd_w, ang_w;
    logic [7:0]           sweep_sum, sweep_mag, pos_mag;
    logic                 start_ok;
    phase_t               phase_cur;

    always_comb
    begin
        cnt_x   = {in_ch.encoder_count[CW-1], in_ch.encoder_count};
        prev_x  = {prev_count_reg[CW-1], prev_count_reg};
        right_x = {right_end_reg[CW-1], right_end_reg};
        mid_x   = {mid_reg[CW-1], mid_reg};
        lim_x   = right_x - SPAN;

        // Truncate toward zero: bias a negative sum up by one before the shift.
        mid_sum = prev_x + right_x;
        mid_adj = mid_sum + {{(DW-1){1'b0}}, mid_sum[DW-1]};

        spd_w = {{2{in_ch.speed_value[7]}}, in_ch.speed_value};
        ang_w = {in_ch.angle_value[8], in_ch.angle_value};

        // Clamp steer magnitudes at the PWM ceiling.
        sweep_sum = {1'b0, turn_reg} + SWEEP_BOOST;
        sweep_mag = (sweep_sum > PWM_MAX) ? PWM_MAX : sweep_sum;
        pos_mag   = ({1'b0, turn_reg} > PWM_MAX) ? PWM_MAX : {1'b0, turn_reg};

        // Writes apply first.
        speed_next = speed_reg;
        angle_next = angle_reg;
        halted_next = halted_reg;
        srej_next = 1'b0;
        arej_next = 1'b0;
        if (in_ch.write_speed)
        begin
            if (spd_w >= SPD_LO && spd_w <= SPD_HI)
                speed_next = in_ch.speed_value;
            else
                srej_next = 1'b1;
        end
        if (in_ch.write_angle)
        begin
            if (ang_w >= ANG_LO && ang_w <= ANG_HI)
                angle_next = in_ch.angle_value;
            else
                arej_next = 1'b1;
        end
        if (in_ch.write_halt)
            halted_next = in_ch.halt_value;

        ang_x = {{(DW-9){angle_next[8]}}, angle_next};

        // Start request: ignored while a sweep runs.
        phase_cur       = phase_reg;
        prev_valid_next = prev_valid_reg;
        start_ok = in_ch.start_calibration && phase_reg != PH_RIGHT
                   && phase_reg != PH_LEFT && phase_reg != PH_CENTER;
        if (start_ok)
        begin
            phase_cur       = PH_RIGHT;
            prev_valid_next = 1'b0;
        end

        phase_next      = phase_cur;
        prev_count_next = prev_count_reg;
        right_end_next  = right_end_reg;
        mid_next        = mid_reg;
        drive_next      = '0;
        steer_next      = '0;
        zero_next       = 1'b0;
        calib_next      = 1'b0;

        case (phase_cur)
            PH_RIGHT:
            begin
                calib_next = 1'b1;
                steer_next = sweep_mag;
                if (prev_valid_next && near(cnt_x, prev_x, jitter_reg))
                begin
                    right_end_next = prev_count_reg;
                    phase_next     = PH_LEFT;
                    steer_next     = 8'(8'd0 - sweep_mag);
                end
                prev_count_next = in_ch.encoder_count;
                prev_valid_next = 1'b1;
            end
            PH_LEFT:
            begin
                calib_next = 1'b1;
                steer_next = 8'(8'd0 - sweep_mag);
                if (prev_valid_next && near(cnt_x, prev_x, jitter_reg)
                    && cnt_x < lim_x)
                begin
                    // Left end is the held sample; latch the midpoint now.
                    mid_next   = mid_adj[DW-1:1];
                    phase_next = PH_CENTER;
                    steer_next = '0;
                end
                prev_count_next = in_ch.encoder_count;
                prev_valid_next = 1'b1;
            end
            PH_CENTER:
            begin
                calib_next = 1'b1;
                if (near(cnt_x, mid_x, jitter_reg))
                begin
                    zero_next  = 1'b1;
                    phase_next = PH_READY;
                end
                else if (cnt_x < mid_x)
                    steer_next = pos_mag;
                else
                    steer_next = 8'(8'd0 - pos_mag);
                prev_count_next = in_ch.encoder_count;
                prev_valid_next = 1'b1;
            end
            PH_READY:
            begin
                if (!halted_next)
                begin
                    drive_next = speed_next;
                    if (!near(cnt_x, ang_x, jitter_reg))
                        steer_next = (cnt_x < ang_x) ? pos_mag : 8'(8'd0 - pos_mag);
                end
            end
            default:
            begin
                // Idle and any stray code: uncalibrated, drive only.
                if (!halted_next)
                    drive_next = speed_next;
            end
        endcase

        iscal_next  = (phase_next == PH_READY);
        center_next = iscal_next && near(cnt_x, '0, jitter_reg);
    end

    // ---------------------------------------------------------------
    // Registers: advance state on each accepted beat
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            prev_count_reg <= '0;
            prev_valid_reg <= 1'b0;
            right_end_reg  <= '0;
            mid_reg        <= '0;
            speed_reg      <= '0;
            angle_reg      <= '0;
            halted_reg     <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg      <= phase_next;
            prev_count_reg <= prev_count_next;
            prev_valid_reg <= prev_valid_next;
            right_end_reg  <= right_end_next;
            mid_reg        <= mid_next;
            speed_reg      <= speed_next;
            angle_reg      <= angle_next;
            halted_reg     <= halted_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload: load on accept, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            drive_reg  <= drive_next;
            steer_reg  <= steer_next;
            zero_reg   <= zero_next;
            iscal_reg  <= iscal_next;
            center_reg <= center_next;
            calib_reg  <= calib_next;
            srej_reg   <= srej_next;
            arej_reg   <= arej_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.drive_pwm      = drive_reg;
    assign out_ch.steer_pwm      = steer_reg;
    assign out_ch.zero_encoder   = zero_reg;
    assign out_ch.is_calibrated  = iscal_reg;
    assign out_ch.is_centered    = center_reg;
    assign out_ch.calibrating    = calib_reg;
    assign out_ch.speed_rejected = srej_reg;
    assign out_ch.angle_rejected = arej_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
`include "steering_calibrate_and_position_core_macros.svh"

    // The zero pulse comes only on the sweep's finishing beat.
    `SCP_ASSERT_NOW(a_zero_on_finish, out_valid_reg && zero_reg, iscal_reg && calib_reg)
    // Propulsion is never driven during a sweep.
    `SCP_ASSERT_NOW(a_no_drive_in_sweep, out_valid_reg && calib_reg, drive_reg == 8'sd0)
    // A start from idle always enters the right sweep.
    `SCP_ASSERT_NEXT(a_start_enters_sweep,
        in_fire && in_ch.start_calibration && phase_reg == PH_IDLE,
        phase_reg == PH_RIGHT || phase_reg == PH_LEFT)

endmodule

`default_nettype wire
